// ===== hw/rtl/bau_pkg.sv =====
package bau_pkg;

  localparam logic [2:0] CMD_AAA = 3'd0;
  localparam logic [2:0] CMD_AAS = 3'd1;
  localparam logic [2:0] CMD_DAA = 3'd2;
  localparam logic [2:0] CMD_DAS = 3'd3;
  localparam logic [2:0] CMD_AAM = 3'd4;
  localparam logic [2:0] CMD_AAD = 3'd5;

  localparam logic [15:0] UNPACK_ADJ = 16'h0106;
  localparam logic [7:0]  LOW_NIBBLE = 8'h0f;
  localparam logic [7:0]  BCD_MAX    = 8'h99;
  localparam logic [7:0]  HIGH_ADJ   = 8'h60;
  localparam logic [7:0]  LOW_ADJ    = 8'h06;
  localparam logic [3:0]  DIGIT_MAX  = 4'd9;

  // one quotient bit per cell
  localparam int DIV_CELLS = 8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] al_in;
    logic [7:0] ah_in;
    logic       af_in;
    logic       cf_in;
    logic [7:0] imm_base;
  } bau_req_t;

  typedef struct packed {
    logic [7:0] al_out;
    logic [7:0] ah_out;
    logic       af_out;
    logic       cf_out;
    logic       sf_out;
    logic       zf_out;
    logic       pf_out;
    logic       szp_written;
    logic       divide_error;
  } bau_rsp_t;

  // item as it travels down the cell chain
  typedef struct packed {
    logic [7:0] al;
    logic [7:0] ah;
    logic       af;
    logic       cf;
    logic       szp;
    logic       derr;
    logic       is_div;
    logic [7:0] divisor;
    logic [7:0] rem;
    logic [7:0] dq;
  } bau_cell_t;

endpackage

// ===== hw/rtl/bau_decode.sv =====
module bau_decode (
  input  bau_pkg::bau_req_t  req,
  output bau_pkg::bau_cell_t item
);
  import bau_pkg::*;

  logic        low_adj;
  logic        high_adj;
  logic [15:0] ax;
  logic [15:0] ax_adj;
  logic [8:0]  daa_low;
  logic [7:0]  das_low;
  logic        low_carry;
  logic [7:0]  al_low;
  logic        cf_low;
  logic [7:0]  al_high;
  logic [15:0] aad_prod;

  assign low_adj  = (req.al_in[3:0] > DIGIT_MAX) || req.af_in;
  assign high_adj = (req.al_in > BCD_MAX) || req.cf_in;
  assign ax       = {req.ah_in, req.al_in};
  assign ax_adj   = (req.cmd == CMD_AAA) ? ax + UNPACK_ADJ : ax - UNPACK_ADJ;
  assign daa_low  = {1'b0, req.al_in} + {1'b0, LOW_ADJ};
  assign das_low  = req.al_in - LOW_ADJ;
  assign aad_prod = req.ah_in * req.imm_base;

  always_comb begin
    if (req.cmd == CMD_DAA) begin
      low_carry = daa_low[8];
    end else begin
      low_carry = req.al_in < LOW_ADJ;
    end
    if (low_adj) begin
      al_low = (req.cmd == CMD_DAA) ? daa_low[7:0] : das_low;
      cf_low = req.cf_in | low_carry;
    end else begin
      al_low = req.al_in;
      cf_low = 1'b0;
    end
    al_high = (req.cmd == CMD_DAA) ? al_low + HIGH_ADJ : al_low - HIGH_ADJ;
  end

  always_comb begin
    item         = '0;
    item.al      = req.al_in;
    item.ah      = req.ah_in;
    item.af      = req.af_in;
    item.cf      = req.cf_in;
    item.divisor = req.imm_base;
    item.dq      = req.al_in;
    case (req.cmd)
      CMD_AAA, CMD_AAS: begin
        if (low_adj) begin
          item.al = ax_adj[7:0] & LOW_NIBBLE;
          item.ah = ax_adj[15:8];
        end else begin
          item.al = req.al_in & LOW_NIBBLE;
        end
        item.af = low_adj;
        item.cf = low_adj;
      end
      CMD_DAA, CMD_DAS: begin
        item.af  = low_adj;
        item.szp = 1'b1;
        if (high_adj) begin
          item.al = al_high;
          item.cf = 1'b1;
        end else begin
          item.al = al_low;
          // das keeps the low borrow, daa clears
          item.cf = (req.cmd == CMD_DAA) ? 1'b0 : cf_low;
        end
      end
      CMD_AAM: begin
        if (req.imm_base == '0) begin
          item.derr = 1'b1;
        end else begin
          item.is_div = 1'b1;
          item.af     = 1'b0;
          item.szp    = 1'b1;
        end
      end
      CMD_AAD: begin
        item.al  = req.al_in + aad_prod[7:0];
        item.ah  = '0;
        item.af  = 1'b0;
        item.szp = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/bau_div_cell.sv =====
module bau_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  bau_pkg::bau_cell_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output bau_pkg::bau_cell_t dn_data
);
  import bau_pkg::*;

  logic      valid;
  bau_cell_t data;
  bau_cell_t data_next;
  logic [8:0] trial;
  logic       fits;

  // one restoring division step: shift in next dividend bit, subtract if it fits
  assign trial = {up_data.rem, up_data.dq[7]};
  assign fits  = trial >= {1'b0, up_data.divisor};

  always_comb begin
    data_next = up_data;
    if (up_data.is_div) begin
      data_next.rem = fits ? 8'(trial - {1'b0, up_data.divisor}) : trial[7:0];
      data_next.dq  = {up_data.dq[6:0], fits};
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

// ===== hw/rtl/bcd_adjust_unit.sv =====
// decimal-adjust execution unit (aaa, aas, daa, das, aam, aad)
// req channel: one instruction beat with opcode, al, ah, af, cf and the
//   immediate byte; taken when req_valid and req_ready are both high
// rsp channel: one result beat per instruction, in order, with new al, ah,
//   af, cf, the sf/zf/pf flags of the new al and the szp_written and
//   divide_error marks
// path: each req beat passes 8 division cells and one output register before
//   rsp_valid; every opcode takes the same path so order is kept
// throughput: one instruction per cycle while rsp_ready stays high; aam's divide
//   runs as a chain of 8 restoring-division cells, one quotient bit per cell
// reset: synchronous, clears all valid bits; nothing else needs clearing
// stall: each cell and the output register hold their beat while the next
//   one is full and stalled; empty slots still fill, so up to 9 beats are
//   buffered before req_ready drops
module bcd_adjust_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bau_pkg::bau_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output bau_pkg::bau_rsp_t rsp
);
  import bau_pkg::*;

  bau_cell_t chain_data  [DIV_CELLS+1];
  logic      chain_valid [DIV_CELLS+1];
  logic      chain_ready [DIV_CELLS+1];

  bau_cell_t last;
  bau_rsp_t  rsp_next;
  logic      valid;
  bau_rsp_t  rsp_q;

  bau_decode u_decode (
    .req  (req),
    .item (chain_data[0])
  );

  assign chain_valid[0] = req_valid;
  assign req_ready      = chain_ready[0];

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    bau_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_data  (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_data  (chain_data[i+1])
    );
  end

  assign last = chain_data[DIV_CELLS];

  always_comb begin
    rsp_next              = '0;
    rsp_next.al_out       = last.is_div ? last.rem : last.al;
    rsp_next.ah_out       = last.is_div ? last.dq : last.ah;
    rsp_next.af_out       = last.af;
    rsp_next.cf_out       = last.cf;
    rsp_next.szp_written  = last.szp;
    rsp_next.divide_error = last.derr;
    if (last.szp) begin
      rsp_next.sf_out = rsp_next.al_out[7];
      rsp_next.zf_out = rsp_next.al_out == '0;
      rsp_next.pf_out = ~^rsp_next.al_out;
    end
  end

  assign chain_ready[DIV_CELLS] = !valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (chain_ready[DIV_CELLS]) begin
      valid <= chain_valid[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_valid[DIV_CELLS] && chain_ready[DIV_CELLS]) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp_valid = valid;
  assign rsp       = rsp_q;

endmodule

// ===== hw/rtl/bau_checker.sv =====
module bau_checker (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input bau_pkg::bau_rsp_t rsp
);
  import bau_pkg::*;

  // stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp beat changed while stalled");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp_valid right after reset");

  // a divide error never updates the flags
  a_derr_no_szp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.divide_error |-> !rsp.szp_written)
    else $error("divide error with flags written");

  // flags agree with al when written, and are clear otherwise
  a_szp_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.szp_written
      ? (rsp.sf_out == rsp.al_out[7] && rsp.zf_out == (rsp.al_out == '0)
         && rsp.pf_out == ~^rsp.al_out)
      : (!rsp.sf_out && !rsp.zf_out && !rsp.pf_out)))
    else $error("sf/zf/pf inconsistent with al_out");

endmodule

bind bcd_adjust_unit bau_checker u_bau_checker (.*);

// ===== verif/tb_bcd_adjust_unit.sv =====
module tb_bcd_adjust_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bau_pkg::*;

  // opcodes 6 and 7 have no instruction behind them
  localparam logic [2:0] CMD_NOP6 = 3'd6;
  localparam logic [2:0] CMD_NOP7 = 3'd7;
  localparam logic [7:0] DECIMAL_BASE = 8'd10;
  localparam int ITEMS_PER_PHASE = 176;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  bau_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  bau_rsp_t rsp;

  bau_rsp_t pending_results[$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       err_count = 0;
  int       beats_by_cmd[8];
  int       div_err_seen = 0;
  int       results_checked = 0;

  bcd_adjust_unit dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("TB_ERROR");
    $finish;
  end

  function automatic bau_rsp_t predict_adjust(bau_req_t r);
    bau_rsp_t    o;
    logic [15:0] ax;
    logic [7:0]  al;
    logic [7:0]  ah;
    logic        af;
    logic        cf;
    logic        szp;
    logic        derr;
    logic        carry;
    al   = r.al_in;
    ah   = r.ah_in;
    af   = r.af_in;
    cf   = r.cf_in;
    szp  = 1'b0;
    derr = 1'b0;
    case (r.cmd)
      CMD_AAA, CMD_AAS: begin
        if (r.al_in[3:0] > DIGIT_MAX || r.af_in) begin
          ax = {r.ah_in, r.al_in};
          if (r.cmd == CMD_AAA) ax = ax + UNPACK_ADJ;
          else ax = ax - UNPACK_ADJ;
          {ah, al} = ax;
          af = 1'b1;
          cf = 1'b1;
        end else begin
          af = 1'b0;
          cf = 1'b0;
        end
        al = al & LOW_NIBBLE;
      end
      CMD_DAA, CMD_DAS: begin
        cf = 1'b0;
        if (r.al_in[3:0] > DIGIT_MAX || r.af_in) begin
          if (r.cmd == CMD_DAA) begin
            {carry, al} = {1'b0, r.al_in} + {1'b0, LOW_ADJ};
          end else begin
            carry = r.al_in < LOW_ADJ;
            al = r.al_in - LOW_ADJ;
          end
          cf = r.cf_in | carry;
          af = 1'b1;
        end else begin
          af = 1'b0;
        end
        // das leaves the low-adjust borrow in cf when the high adjust is skipped
        if (r.al_in > BCD_MAX || r.cf_in) begin
          al = (r.cmd == CMD_DAA) ? al + HIGH_ADJ : al - HIGH_ADJ;
          cf = 1'b1;
        end else if (r.cmd == CMD_DAA) begin
          cf = 1'b0;
        end
        szp = 1'b1;
      end
      CMD_AAM: begin
        if (r.imm_base == 8'h00) begin
          derr = 1'b1;
        end else begin
          ah  = r.al_in / r.imm_base;
          al  = r.al_in % r.imm_base;
          af  = 1'b0;
          szp = 1'b1;
        end
      end
      CMD_AAD: begin
        al  = r.al_in + r.ah_in * r.imm_base;
        ah  = 8'h00;
        af  = 1'b0;
        szp = 1'b1;
      end
      default: ;
    endcase
    o.al_out       = al;
    o.ah_out       = ah;
    o.af_out       = af;
    o.cf_out       = cf;
    o.sf_out       = szp & al[7];
    o.zf_out       = szp & (al == 8'h00);
    o.pf_out       = szp & ~(^al);
    o.szp_written  = szp;
    o.divide_error = derr;
    return o;
  endfunction

  function automatic string fmt_rsp(bau_rsp_t v);
    return $sformatf("al=%h ah=%h af=%b cf=%b sf=%b zf=%b pf=%b szp=%b de=%b",
                     v.al_out, v.ah_out, v.af_out, v.cf_out, v.sf_out, v.zf_out,
                     v.pf_out, v.szp_written, v.divide_error);
  endfunction

  function automatic bau_req_t mk_instr(logic [2:0] cmd, logic [7:0] al, logic [7:0] ah,
                                        logic af, logic cf, logic [7:0] imm);
    bau_req_t r;
    r.cmd      = cmd;
    r.al_in    = al;
    r.ah_in    = ah;
    r.af_in    = af;
    r.cf_in    = cf;
    r.imm_base = imm;
    return r;
  endfunction

  function automatic bau_req_t rand_instr();
    bau_req_t r;
    int       pick;
    r = bau_req_t'({$urandom, $urandom});
    if ($urandom_range(99) < 4) r.cmd = $urandom_range(1) ? CMD_NOP7 : CMD_NOP6;
    else r.cmd = 3'($urandom_range(5));
    // a third of the time al holds two valid decimal digits
    if ($urandom_range(2) == 0) r.al_in = {4'($urandom_range(9)), 4'($urandom_range(9))};
    pick = $urandom_range(7);
    if (pick == 0) r.imm_base = 8'h00;
    else if (pick < 3) r.imm_base = DECIMAL_BASE;
    return r;
  endfunction

  task automatic send_instr(bau_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      req = bau_req_t'({$urandom, $urandom});
      @(negedge clk);
    end
    req_valid = 1'b1;
    req = r;
    do @(posedge clk); while (!req_ready);
    pending_results.push_back(predict_adjust(r));
    beats_by_cmd[r.cmd]++;
    if (r.cmd == CMD_AAM && r.imm_base == 8'h00) div_err_seen++;
  endtask

  task automatic send_random(int n);
    repeat (n) send_instr(rand_instr());
  endtask

  always @(negedge clk) begin
    rsp_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    bau_rsp_t exp_rsp;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result beat: %s", fmt_rsp(rsp));
      end else begin
        exp_rsp = pending_results.pop_front();
        results_checked++;
        if (rsp !== exp_rsp) begin
          err_count++;
          if (err_count <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  exp %s", fmt_rsp(exp_rsp));
            $display("  got %s", fmt_rsp(rsp));
          end
        end
      end
    end
  end

  task automatic test_corner_cases();
    bau_req_t items[$];
    items = '{
      mk_instr(CMD_AAA, 8'h09, 8'h00, 1'b0, 1'b0, 8'h00),
      mk_instr(CMD_AAA, 8'h0a, 8'hff, 1'b0, 1'b0, 8'h00),
      mk_instr(CMD_AAA, 8'hff, 8'hff, 1'b1, 1'b1, 8'hff),
      mk_instr(CMD_AAS, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00),
      mk_instr(CMD_AAS, 8'h0f, 8'h05, 1'b0, 1'b0, 8'h00),
      mk_instr(CMD_AAS, 8'h39, 8'h01, 1'b0, 1'b1, 8'h00),
      mk_instr(CMD_DAA, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00),
      mk_instr(CMD_DAA, 8'h99, 8'h00, 1'b0, 1'b0, 8'h00),
      mk_instr(CMD_DAA, 8'h9a, 8'h00, 1'b0, 1'b0, 8'h00),
      mk_instr(CMD_DAA, 8'hff, 8'hff, 1'b1, 1'b1, 8'hff),
      mk_instr(CMD_DAA, 8'h0f, 8'h00, 1'b0, 1'b0, 8'h00),
      mk_instr(CMD_DAS, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00),
      mk_instr(CMD_DAS, 8'h03, 8'h00, 1'b1, 1'b0, 8'h00),
      mk_instr(CMD_DAS, 8'h9a, 8'h00, 1'b0, 1'b0, 8'h00),
      mk_instr(CMD_DAS, 8'hff, 8'hff, 1'b1, 1'b1, 8'hff),
      mk_instr(CMD_DAS, 8'h55, 8'h00, 1'b0, 1'b0, 8'h00),
      mk_instr(CMD_AAM, 8'hff, 8'h12, 1'b1, 1'b1, 8'h00),
      mk_instr(CMD_AAM, 8'hff, 8'h00, 1'b1, 1'b0, 8'h01),
      mk_instr(CMD_AAM, 8'hff, 8'hff, 1'b0, 1'b1, 8'hff),
      mk_instr(CMD_AAM, 8'h00, 8'h00, 1'b0, 1'b0, DECIMAL_BASE),
      mk_instr(CMD_AAM, 8'h63, 8'h00, 1'b0, 1'b0, DECIMAL_BASE),
      mk_instr(CMD_AAD, 8'hff, 8'hff, 1'b1, 1'b1, 8'hff),
      mk_instr(CMD_AAD, 8'h09, 8'h09, 1'b0, 1'b0, DECIMAL_BASE),
      mk_instr(CMD_NOP6, 8'hff, 8'hff, 1'b1, 1'b1, 8'hff),
      mk_instr(CMD_NOP7, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00)
    };
    foreach (items[i]) send_instr(items[i]);
  endtask

  task automatic test_slow_receiver();
    send_idle_pct = 7;
    recv_idle_pct = 79;
    send_random(ITEMS_PER_PHASE);
  endtask

  task automatic test_slow_sender();
    send_idle_pct = 79;
    recv_idle_pct = 7;
    send_random(ITEMS_PER_PHASE);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(ITEMS_PER_PHASE);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 79;
    test_corner_cases();
    test_slow_receiver();
    test_slow_sender();
    test_full_rate();
    @(negedge clk);
    req_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("checked %0d results: aaa %0d aas %0d daa %0d das %0d aam %0d aad %0d",
             results_checked, beats_by_cmd[CMD_AAA], beats_by_cmd[CMD_AAS],
             beats_by_cmd[CMD_DAA], beats_by_cmd[CMD_DAS], beats_by_cmd[CMD_AAM],
             beats_by_cmd[CMD_AAD]);
    $display("unused opcodes %0d, aam divide errors %0d, failures %0d",
             beats_by_cmd[CMD_NOP6] + beats_by_cmd[CMD_NOP7], div_err_seen, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bau_pkg.sv
hw/rtl/bau_decode.sv
hw/rtl/bau_div_cell.sv
hw/rtl/bcd_adjust_unit.sv
hw/rtl/bau_checker.sv
verif/tb_bcd_adjust_unit.sv
